[design/sdc_pkg.sv]
// sd card spi command engine: shared types and constants
// holds the phase encoding, the engine state record and the result record
// no dependencies
package sdc_pkg;

	// exchange codes carried on the request channel
	localparam logic OP_START = 1'b0;
	localparam logic OP_XCHG  = 1'b1;

	// command numbers with special handling
	localparam logic [5:0] CMD_IF_COND  = 6'd8;
	localparam logic [5:0] CMD_READ_OCR = 6'd58;
	localparam logic [5:0] CMD_RD_SINGLE = 6'd17;
	localparam logic [5:0] CMD_RD_MULTI  = 6'd18;
	localparam logic [5:0] CMD_WR_SINGLE = 6'd24;
	localparam logic [5:0] CMD_WR_MULTI  = 6'd25;
	localparam logic [5:0] CMD_ERASE_ST  = 6'd32;
	localparam logic [5:0] CMD_ERASE_END = 6'd33;

	// frame and filler bytes
	localparam logic [7:0] CMD_PREFIX = 8'h40;
	localparam logic [7:0] CRC_CMD8   = 8'h87;
	localparam logic [7:0] CRC_OTHER  = 8'h95;
	localparam logic [7:0] FILL_BYTE  = 8'hFF;

	// block to byte address shift for standard capacity cards
	localparam int unsigned BLOCK_SHIFT = 9;

	localparam logic [2:0] FRAME_LEN  = 3'd6;
	localparam logic [2:0] SKIP_R7    = 3'd5;
	localparam logic [2:0] SKIP_OCR   = 3'd3;
	localparam logic [7:0] POLL_LIMIT_RST = 8'hFF;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_FRAME = 3'd1,
		PH_POLL  = 3'd2,
		PH_OCR   = 3'd3,
		PH_SKIP  = 3'd4,
		PH_TRAIL = 3'd5
	} sdc_phase_t;

	typedef struct packed {
		sdc_phase_t  phase;
		logic [2:0]  frame_index;
		logic [31:0] arg;
		logic [5:0]  cmd;
		logic [8:0]  poll_count;
		logic [7:0]  response;
		logic [2:0]  skip_count;
		logic        high_capacity;
	} sdc_state_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       chip_select;
		logic       done_res;
		logic [7:0] response;
		logic       high_capacity;
	} sdc_result_t;

endpackage

[design/sdc_if.sv]
// sd card spi command engine: channel interfaces
// request, result and configuration channels with valid/ready handshakes
// no dependencies

// request channel: start or completed exchange
interface sdc_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [5:0]  cmd_index;
	logic [31:0] argument;
	logic [7:0]  rx_byte;

	modport source (output valid, opcode, cmd_index, argument, rx_byte, input ready);
	modport sink   (input valid, opcode, cmd_index, argument, rx_byte, output ready);
endinterface

// result channel: next byte and status
interface sdc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_valid;
	logic       chip_select;
	logic       done_res;
	logic [7:0] response;
	logic       high_capacity;

	modport source (output valid, tx_byte, tx_valid, chip_select, done_res, response,
		high_capacity, input ready);
	modport sink   (input valid, tx_byte, tx_valid, chip_select, done_res, response,
		high_capacity, output ready);
endinterface

// configuration channel: poll limit write
interface sdc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[design/sdc_step.sv]
// sd card spi command engine: next state and result for one beat
// purely combinational, one request beat in, one result out
// depends on sdc_pkg
module sdc_step
	import sdc_pkg::*;
(
	input  sdc_state_t  cur,
	input  logic        opcode,
	input  logic [5:0]  cmd_index,
	input  logic [31:0] argument,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  poll_limit,
	output sdc_state_t  nxt,
	output sdc_result_t res
);

	logic        data_cmd;
	logic [31:0] start_arg;
	logic [7:0]  frame_byte;
	logic [2:0]  skip_dec;
	logic        poll_end;

	// block-addressed data commands
	assign data_cmd = (cmd_index == CMD_RD_SINGLE) || (cmd_index == CMD_RD_MULTI) ||
		(cmd_index == CMD_WR_SINGLE) || (cmd_index == CMD_WR_MULTI) ||
		(cmd_index == CMD_ERASE_ST) || (cmd_index == CMD_ERASE_END);

	// byte address for standard capacity cards
	assign start_arg = (!cur.high_capacity && data_cmd) ?
		{argument[31-BLOCK_SHIFT:0], {BLOCK_SHIFT{1'b0}}} : argument;

	// frame byte for the current frame index
	always_comb begin
		unique case (cur.frame_index)
			3'd1:    frame_byte = cur.arg[31:24];
			3'd2:    frame_byte = cur.arg[23:16];
			3'd3:    frame_byte = cur.arg[15:8];
			3'd4:    frame_byte = cur.arg[7:0];
			default: frame_byte = (cur.cmd == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
		endcase
	end

	assign skip_dec = cur.skip_count - 3'd1;
	assign poll_end = (rx_byte != FILL_BYTE) || (cur.poll_count >= {1'b0, poll_limit});

	// phase update and outgoing byte
	always_comb begin
		nxt             = cur;
		res.tx_byte     = 8'h00;
		res.tx_valid    = 1'b0;
		res.chip_select = 1'b0;
		res.done_res    = 1'b0;
		if (opcode == OP_START) begin
			nxt.cmd         = cmd_index;
			nxt.arg         = start_arg;
			nxt.response    = FILL_BYTE;
			nxt.poll_count  = 9'd0;
			nxt.skip_count  = 3'd0;
			nxt.phase       = PH_FRAME;
			nxt.frame_index = 3'd1;
			res.tx_byte     = {2'b00, cmd_index} | CMD_PREFIX;
			res.tx_valid    = 1'b1;
			res.chip_select = 1'b1;
		end else begin
			unique case (cur.phase)
				PH_FRAME: begin
					res.chip_select = 1'b1;
					res.tx_valid    = 1'b1;
					if (cur.frame_index < FRAME_LEN) begin
						res.tx_byte     = frame_byte;
						nxt.frame_index = cur.frame_index + 3'd1;
					end else begin
						nxt.phase      = PH_POLL;
						nxt.poll_count = 9'd0;
						res.tx_byte    = FILL_BYTE;
					end
				end
				PH_POLL: begin
					res.chip_select = 1'b1;
					res.tx_valid    = 1'b1;
					res.tx_byte     = FILL_BYTE;
					if (poll_end) begin
						nxt.response = rx_byte;
						if (cur.cmd == CMD_READ_OCR && rx_byte == 8'h00) begin
							nxt.phase = PH_OCR;
						end else if (cur.cmd == CMD_IF_COND && rx_byte == 8'h01) begin
							nxt.phase      = PH_SKIP;
							nxt.skip_count = SKIP_R7;
						end else begin
							nxt.phase = PH_TRAIL;
						end
					end else begin
						nxt.poll_count = cur.poll_count + 9'd1;
					end
				end
				PH_OCR: begin
					res.chip_select   = 1'b1;
					res.tx_valid      = 1'b1;
					res.tx_byte       = FILL_BYTE;
					nxt.high_capacity = rx_byte[6];
					nxt.skip_count    = SKIP_OCR;
					nxt.phase         = PH_SKIP;
				end
				PH_SKIP: begin
					res.chip_select = 1'b1;
					res.tx_valid    = 1'b1;
					res.tx_byte     = FILL_BYTE;
					nxt.skip_count  = skip_dec;
					if (skip_dec == 3'd0) begin
						nxt.phase = PH_TRAIL;
					end
				end
				PH_TRAIL: begin
					nxt.phase    = PH_IDLE;
					res.done_res = 1'b1;
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
		res.response      = nxt.response;
		res.high_capacity = nxt.high_capacity;
	end

endmodule

[design/sd_spi_command_engine.sv]
// sd card spi command engine: top level
// engine state register, result register and poll limit register
// depends on sdc_pkg, sdc_if and sdc_step
//
//  channel  dir  payload                                           beat when
//  req      in   opcode, cmd_index, argument, rx_byte              valid & ready
//  rsp      out  tx_byte, tx_valid, chip_select, done_res,
//                response, high_capacity                           valid & ready
//  cfg      in   data (poll limit)                                 valid & ready
//
// each request beat yields one result beat; the result appears in the cycle after
// the request is taken, and a new request is taken every cycle while the result
// register is empty or draining. latency and rate are set by the single state
// update between the engine state register and the result register.
// reset clears the engine to idle, response to 0xff and the poll limit to 255.
// a stalled result holds the request side only when the result register is full.
module sd_spi_command_engine
	import sdc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sdc_req_if.sink   req,
	sdc_rsp_if.source rsp,
	sdc_cfg_if.sink   cfg
);

	sdc_state_t  state_q;
	sdc_state_t  state_d;
	sdc_result_t res_d;
	sdc_result_t res_q;
	logic        rsp_valid_q;
	logic [7:0]  poll_limit_q;
	logic        req_beat;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_beat  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// per-beat state update
	sdc_step u_step (
		.cur        (state_q),
		.opcode     (req.opcode),
		.cmd_index  (req.cmd_index),
		.argument   (req.argument),
		.rx_byte    (req.rx_byte),
		.poll_limit (poll_limit_q),
		.nxt        (state_d),
		.res        (res_d)
	);

	// poll limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			poll_limit_q <= cfg.data;
		end
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.frame_index   <= 3'd0;
			state_q.arg           <= 32'd0;
			state_q.cmd           <= 6'd0;
			state_q.poll_count    <= 9'd0;
			state_q.response      <= FILL_BYTE;
			state_q.skip_count    <= 3'd0;
			state_q.high_capacity <= 1'b0;
		end else if (req_beat) begin
			state_q <= state_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (req_beat) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.tx_byte       = res_q.tx_byte;
	assign rsp.tx_valid      = res_q.tx_valid;
	assign rsp.chip_select   = res_q.chip_select;
	assign rsp.done_res      = res_q.done_res;
	assign rsp.response      = res_q.response;
	assign rsp.high_capacity = res_q.high_capacity;

endmodule
